// ===== rtl/tori_pkg.sv =====
// shared constants and types for the triangle orientation test
// no dependencies
`default_nettype none
package tori_pkg;

	// limb width used when splitting wide products into partial products
	localparam int LIMB_W = 16;

	typedef struct packed {
		logic swap_needed;
		logic degenerate_vertex;
	} tori_res_t;

endpackage
`default_nettype wire

// ===== rtl/tori_req_if.sv =====
// request and response channel interfaces of the orientation test
// depends on nothing but the coordinate width parameter
`default_nettype none
interface tori_req_if #(
	parameter int COORD_WIDTH = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] v1_x;
	logic signed [COORD_WIDTH-1:0] v1_y;
	logic signed [COORD_WIDTH-1:0] v1_z;
	logic signed [COORD_WIDTH-1:0] v2_x;
	logic signed [COORD_WIDTH-1:0] v2_y;
	logic signed [COORD_WIDTH-1:0] v2_z;
	logic signed [COORD_WIDTH-1:0] v3_x;
	logic signed [COORD_WIDTH-1:0] v3_y;
	logic signed [COORD_WIDTH-1:0] v3_z;

	modport source (output valid, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z,
		input ready);
	modport sink (input valid, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z,
		output ready);
endinterface

interface tori_rsp_if;
	logic valid;
	logic ready;
	logic swap_needed;
	logic degenerate_vertex;

	modport source (output valid, swap_needed, degenerate_vertex, input ready);
	modport sink (input valid, swap_needed, degenerate_vertex, output ready);
endinterface
`default_nettype wire

// ===== rtl/tori_mul.sv =====
// three-stage signed multiplier built from limb partial products
// depends on tori_pkg for the limb width
`default_nettype none
module tori_mul #(
	parameter int WA = 24,
	parameter int WB = 24
) (
	input  wire logic                  clk,
	input  wire logic                  en,
	input  wire logic signed [WA-1:0]  a,
	input  wire logic signed [WB-1:0]  b,
	output logic signed [WA+WB-1:0]    p
);
	import tori_pkg::*;

	localparam int NA = (WA + LIMB_W - 1) / LIMB_W;
	localparam int NB = (WB + LIMB_W - 1) / LIMB_W;
	localparam int PW = WA + WB;
	localparam int PPW = 2 * LIMB_W + 2;

	logic signed [NA*LIMB_W-1:0] ax;
	logic signed [NB*LIMB_W-1:0] bx;
	logic signed [LIMB_W:0]      la [NA];
	logic signed [LIMB_W:0]      lb [NB];
	logic signed [PPW-1:0]       pp_s1 [NA][NB];
	logic signed [PW-1:0]        row_s2 [NA];
	logic signed [PW-1:0]        row_sum [NA];
	logic signed [PW-1:0]        p_sum;
	logic signed [PW-1:0]        p_s3;

	assign ax = (NA*LIMB_W)'(a);
	assign bx = (NB*LIMB_W)'(b);

	// low limbs unsigned, top limb carries the sign
	always_comb begin
		for (int i = 0; i < NA; i++) begin
			if (i == NA - 1)
				la[i] = {ax[NA*LIMB_W-1], ax[i*LIMB_W +: LIMB_W]};
			else
				la[i] = {1'b0, ax[i*LIMB_W +: LIMB_W]};
		end
		for (int j = 0; j < NB; j++) begin
			if (j == NB - 1)
				lb[j] = {bx[NB*LIMB_W-1], bx[j*LIMB_W +: LIMB_W]};
			else
				lb[j] = {1'b0, bx[j*LIMB_W +: LIMB_W]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++)
				for (int j = 0; j < NB; j++)
					pp_s1[i][j] <= PPW'(la[i] * lb[j]);
		end
	end

	always_comb begin
		for (int i = 0; i < NA; i++) begin
			row_sum[i] = '0;
			for (int j = 0; j < NB; j++)
				row_sum[i] = row_sum[i] + (PW'(pp_s1[i][j]) <<< (LIMB_W * j));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++)
				row_s2[i] <= row_sum[i];
		end
	end

	always_comb begin
		p_sum = '0;
		for (int i = 0; i < NA; i++)
			p_sum = p_sum + (row_s2[i] <<< (LIMB_W * i));
	end

	always_ff @(posedge clk) begin
		if (en)
			p_s3 <= p_sum;
	end

	assign p = p_s3;

endmodule
`default_nettype wire

// ===== rtl/triangle_outward_orientation_test_top.sv =====
// triangle orientation test, top level
// depends on tori_pkg, tori_req_if, tori_rsp_if and tori_mul
`default_nettype none
// Takes one triangle per cycle and reports whether its winding points inward
// (swap_needed) by the exact sign of det(v1,v2,v3), and flags any vertex at the
// origin (degenerate_vertex, which forces swap_needed low). The pipeline is nine
// register stages deep: an input register, two three-stage multiplier banks for
// the 2x2 minors and the final triple products, a minor subtract stage and the
// output register holding the result. A new request is taken every cycle; the
// whole pipeline holds while the output register waits on rsp.ready.
module triangle_outward_orientation_test_top #(
	parameter int COORD_WIDTH = 24
) (
	input  wire logic clk,
	input  wire logic arst_n,
	tori_req_if.sink   req,
	tori_rsp_if.source rsp
);
	import tori_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int MW = 2 * CW + 1;
	localparam int TW = CW + MW;
	localparam int DW = TW + 2;

	logic en;

	logic signed [CW-1:0] x1_s1, y1_s1, z1_s1, x2_s1, y2_s1, z2_s1, x3_s1, y3_s1, z3_s1;
	logic                 deg_in;

	// per stage 1..8, index 0 is stage 1
	logic [7:0]           vld_q;
	logic [7:0]           deg_q;
	// first vertex carried from stage 2 to stage 5, index 0 is stage 2
	logic signed [CW-1:0] v1x_q [4];
	logic signed [CW-1:0] v1y_q [4];
	logic signed [CW-1:0] v1z_q [4];

	logic signed [CW-1:0]   ma [6];
	logic signed [CW-1:0]   mb [6];
	logic signed [2*CW-1:0] mp [6];

	logic signed [MW-1:0] m1_s5, m2_s5, m3_s5;
	logic signed [TW-1:0] t1, t2, t3;
	logic signed [DW-1:0] det;

	logic      rsp_valid_q;
	tori_res_t res_q;

	assign en = !rsp_valid_q || rsp.ready;
	assign req.ready = en;

	assign deg_in = ((req.v1_x == '0) && (req.v1_y == '0) && (req.v1_z == '0))
		|| ((req.v2_x == '0) && (req.v2_y == '0) && (req.v2_z == '0))
		|| ((req.v3_x == '0) && (req.v3_y == '0) && (req.v3_z == '0));

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s1 <= req.v1_x;
			y1_s1 <= req.v1_y;
			z1_s1 <= req.v1_z;
			x2_s1 <= req.v2_x;
			y2_s1 <= req.v2_y;
			z2_s1 <= req.v2_z;
			x3_s1 <= req.v3_x;
			y3_s1 <= req.v3_y;
			z3_s1 <= req.v3_z;
			deg_q <= {deg_q[6:0], deg_in};
			v1x_q[0] <= x1_s1;
			v1y_q[0] <= y1_s1;
			v1z_q[0] <= z1_s1;
			for (int k = 1; k < 4; k++) begin
				v1x_q[k] <= v1x_q[k-1];
				v1y_q[k] <= v1y_q[k-1];
				v1z_q[k] <= v1z_q[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[6:0], req.valid};
		end
	end

	// 2x2 minors of vertices 2 and 3
	assign ma[0] = y2_s1;  assign mb[0] = z3_s1;
	assign ma[1] = z2_s1;  assign mb[1] = y3_s1;
	assign ma[2] = x2_s1;  assign mb[2] = z3_s1;
	assign ma[3] = z2_s1;  assign mb[3] = x3_s1;
	assign ma[4] = x2_s1;  assign mb[4] = y3_s1;
	assign ma[5] = y2_s1;  assign mb[5] = x3_s1;

	for (genvar g = 0; g < 6; g++) begin : g_minor
		tori_mul #(.WA(CW), .WB(CW)) u_mul (
			.clk    (clk),
			.en     (en),
			.a      (ma[g]),
			.b      (mb[g]),
			.p      (mp[g])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m1_s5 <= MW'(mp[0]) - MW'(mp[1]);
			m2_s5 <= MW'(mp[2]) - MW'(mp[3]);
			m3_s5 <= MW'(mp[4]) - MW'(mp[5]);
		end
	end

	tori_mul #(.WA(CW), .WB(MW)) u_mul_x (
		.clk(clk), .en(en), .a(v1x_q[3]), .b(m1_s5), .p(t1)
	);
	tori_mul #(.WA(CW), .WB(MW)) u_mul_y (
		.clk(clk), .en(en), .a(v1y_q[3]), .b(m2_s5), .p(t2)
	);
	tori_mul #(.WA(CW), .WB(MW)) u_mul_z (
		.clk(clk), .en(en), .a(v1z_q[3]), .b(m3_s5), .p(t3)
	);

	assign det = DW'(t1) - DW'(t2) + DW'(t3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			rsp_valid_q <= vld_q[7];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.swap_needed       <= det[DW-1] && !deg_q[7];
			res_q.degenerate_vertex <= deg_q[7];
		end
	end

	assign rsp.valid             = rsp_valid_q;
	assign rsp.swap_needed       = res_q.swap_needed;
	assign rsp.degenerate_vertex = res_q.degenerate_vertex;

endmodule
`default_nettype wire

// ===== rtl/tori_checker.sv =====
// port-level checks for the triangle orientation test
// binds to triangle_outward_orientation_test_top
`default_nettype none
module tori_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire logic swap_needed,
	input wire logic degenerate_vertex
);
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(swap_needed && degenerate_vertex))
		else $error("swap flagged on a degenerate triangle");

	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("request taken while result is stalled");

	a_free_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request refused with empty output");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(swap_needed)
			&& $stable(degenerate_vertex))
		else $error("stalled result changed");
endmodule

bind triangle_outward_orientation_test_top tori_checker u_tori_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.swap_needed       (rsp.swap_needed),
	.degenerate_vertex (rsp.degenerate_vertex)
);
`default_nettype wire

// ===== sim/tb_triangle_outward_orientation_test_top.sv =====
// testbench for the triangle orientation test: drives triangles, checks each response
// against a determinant-sign predictor; depends on tori_pkg, tori_req_if, tori_rsp_if
`default_nettype none
module tb_triangle_outward_orientation_test_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tori_pkg::*;

	localparam int CW = 24;
	localparam int N_DIRECTED = 20;
	localparam int N_RANDOM = 1900;
	localparam int N_CALM = 300;
	localparam int LIMIT = 400000;

	typedef logic signed [CW-1:0] coord_t;
	typedef struct {
		coord_t c[9];
	} tri_t;

	class orient_board;
		tori_res_t pending[$];
		int errors = 0;

		function tori_res_t orientation_of(tri_t t);
			tori_res_t r;
			logic signed [3*CW+4:0] det;
			logic signed [2*CW+2:0] m1, m2, m3;
			r.swap_needed = 1'b0;
			r.degenerate_vertex = 1'b0;
			for (int k = 0; k < 3; k++)
				if (t.c[3*k] == 0 && t.c[3*k+1] == 0 && t.c[3*k+2] == 0)
					r.degenerate_vertex = 1'b1;
			if (r.degenerate_vertex)
				return r;
			m1 = t.c[4] * t.c[8] - t.c[5] * t.c[7];
			m2 = t.c[3] * t.c[8] - t.c[5] * t.c[6];
			m3 = t.c[3] * t.c[7] - t.c[4] * t.c[6];
			det = t.c[0] * m1 - t.c[1] * m2 + t.c[2] * m3;
			r.swap_needed = det < 0;
			return r;
		endfunction

		function void note_triangle(tri_t t);
			pending = {pending, orientation_of(t)};
		endfunction

		function void check_result(logic swap, logic degen);
			tori_res_t e;
			if (pending.size() == 0) begin
				$error("response with no request outstanding");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (swap !== e.swap_needed) begin
				$error("swap_needed: expected %0b, got %0b", e.swap_needed, swap);
				errors++;
			end
			if (degen !== e.degenerate_vertex) begin
				$error("degenerate_vertex: expected %0b, got %0b", e.degenerate_vertex, degen);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic calm = 1'b0;
	logic sending_done = 1'b0;
	int cycles = 0;
	orient_board board = new();

	tori_req_if #(.COORD_WIDTH(CW)) req ();
	tori_rsp_if rsp ();

	triangle_outward_orientation_test_top #(.COORD_WIDTH(CW)) uut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb_triangle_outward_orientation_test_top: done, errors");
			$finish;
		end
	end

	task automatic put_triangle(tri_t t);
		req.valid <= 1'b1;
		req.v1_x <= t.c[0]; req.v1_y <= t.c[1]; req.v1_z <= t.c[2];
		req.v2_x <= t.c[3]; req.v2_y <= t.c[4]; req.v2_z <= t.c[5];
		req.v3_x <= t.c[6]; req.v3_y <= t.c[7]; req.v3_z <= t.c[8];
		do @(posedge clk); while (!req.ready);
		board.note_triangle(t);
		@(negedge clk);
	endtask

	task automatic gap_maybe();
		int n;
		if (!calm && $urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, 18);
			req.valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 5))
			0: return coord_t'(0);
			1: return {1'b1, {(CW-1){1'b0}}};
			2: return {1'b0, {(CW-1){1'b1}}};
			3: return coord_t'(int'($urandom_range(0, 7)) - 3);
			default: return coord_t'($urandom);
		endcase
	endfunction

	function automatic tri_t rand_triangle();
		tri_t t;
		int v;
		for (int i = 0; i < 9; i++)
			t.c[i] = rand_coord();
		v = int'($urandom_range(0, 2));
		case ($urandom_range(0, 7))
			// repeated vertex gives a zero determinant
			0: for (int i = 0; i < 3; i++) t.c[6+i] = t.c[i];
			// vertex exactly at the origin
			1: for (int i = 0; i < 3; i++) t.c[3*v+i] = '0;
			// third vertex along the first
			2: for (int i = 0; i < 3; i++) t.c[6+i] = -t.c[i];
			default: ;
		endcase
		return t;
	endfunction

	function automatic tri_t directed_triangle(int k);
		tri_t t;
		coord_t mx, mn;
		mx = {1'b0, {(CW-1){1'b1}}};
		mn = {1'b1, {(CW-1){1'b0}}};
		for (int i = 0; i < 9; i++)
			t.c[i] = '0;
		case (k)
			0: begin t.c[0] = coord_t'(1); t.c[4] = coord_t'(1); t.c[8] = coord_t'(1); end
			1: begin t.c[0] = coord_t'(1); t.c[4] = coord_t'(1); t.c[8] = coord_t'(-1); end
			2: ;
			3: begin t.c[0] = coord_t'(5); t.c[4] = coord_t'(7); end
			4: begin t.c[0] = mx; t.c[4] = mx; t.c[8] = mx; end
			5: begin t.c[0] = mn; t.c[4] = mn; t.c[8] = mn; end
			6: begin t.c[0] = mn; t.c[4] = mx; t.c[8] = mx; end
			7: for (int i = 0; i < 9; i++) t.c[i] = mn;
			8: for (int i = 0; i < 9; i++) t.c[i] = mx;
			9: for (int i = 0; i < 9; i++) t.c[i] = coord_t'(-1);
			10: begin t.c[0] = mx; t.c[1] = mn; t.c[2] = mx; t.c[3] = mn; t.c[4] = mx;
				t.c[5] = mn; t.c[6] = mx; t.c[7] = mx; t.c[8] = mn; end
			11: begin t.c[0] = mn; t.c[1] = mx; t.c[2] = mn; t.c[3] = mx; t.c[4] = mn;
				t.c[5] = mx; t.c[6] = mn; t.c[7] = mn; t.c[8] = mx; end
			// coplanar with the origin
			12: begin t.c[0] = coord_t'(1); t.c[1] = coord_t'(2); t.c[3] = coord_t'(3);
				t.c[4] = coord_t'(4); t.c[6] = coord_t'(5); t.c[7] = coord_t'(6); end
			13: begin t.c[1] = coord_t'(1); t.c[3] = coord_t'(1); t.c[8] = coord_t'(1); end
			default: t = rand_triangle();
		endcase
		return t;
	endfunction

	// response side: random stall bursts, none once calm
	initial begin
		int n;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 18);
				rsp.ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			rsp.ready <= 1'b1;
		end
	end

	always @(posedge clk)
		if (arst_n && rsp.valid && rsp.ready)
			board.check_result(rsp.swap_needed, rsp.degenerate_vertex);

	initial begin
		tri_t t;
		req.valid = 1'b0;
		{req.v1_x, req.v1_y, req.v1_z} = '0;
		{req.v2_x, req.v2_y, req.v2_z} = '0;
		{req.v3_x, req.v3_y, req.v3_z} = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		for (int k = 0; k < N_DIRECTED; k++) begin
			gap_maybe();
			put_triangle(directed_triangle(k));
		end
		for (int k = 0; k < N_RANDOM; k++) begin
			if (k == N_RANDOM - N_CALM)
				calm = 1'b1;
			gap_maybe();
			put_triangle(rand_triangle());
		end
		req.valid <= 1'b0;
		while (board.pending.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (board.errors == 0)
			$display("tb_triangle_outward_orientation_test_top: done, clean");
		else
			$display("tb_triangle_outward_orientation_test_top: done, errors");
		$finish;
	end
endmodule
`default_nettype wire
